// ===== design/vca_pkg.sv =====
package vca_pkg;

    // Field widths fixed by the request and result formats
    localparam int SOUND_W    = 16;
    localparam int TICK_W     = 32;
    localparam int PTIME_W    = 32;
    localparam int MASK_W     = 8;
    localparam int MASK_BIT_W = 3;
    localparam int CHAN_W     = 3;
    localparam int LIMIT_W    = 4;

    // Row size: default and the widths that cover the largest supported row (64)
    localparam int CHANNELS_DEF = 8;
    localparam int CH_IDX_W     = 6;
    localparam int CH_CNT_W     = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

    // Request codes
    typedef enum logic [1:0] {
        REQ_PLAY   = 2'd0,
        REQ_PAUSE  = 2'd1,
        REQ_RESUME = 2'd2,
        REQ_STOP   = 2'd3
    } t_req_type;

    // Request fields broadcast to every cell while a pass runs
    typedef struct packed {
        logic               play;
        logic [SOUND_W-1:0] sound;
        logic [MASK_W-1:0]  mask;
    } t_req;

    // Partial result handed from cell to cell
    typedef struct packed {
        logic                valid;
        logic [CH_CNT_W-1:0] cnt;
        logic                found;
        logic [CH_IDX_W-1:0] best_idx;
        logic [TICK_W-1:0]   best_tick;
        logic                free_found;
        logic [CH_IDX_W-1:0] free_idx;
        logic                match_found;
        logic [CH_IDX_W-1:0] match_idx;
    } t_carry;

    // Slot write broadcast to the row
    typedef struct packed {
        logic                en;
        logic [CH_IDX_W-1:0] idx;
        logic [SOUND_W-1:0]  sound;
        logic [TICK_W-1:0]   tick;
    } t_wr;

endpackage

// ===== design/voice_channel_allocator.sv =====
// Voice channel allocator: hands mixer channels to sound requests.
// Input channel: i_valid / o_ready carry one request (type, sound id, tick,
// play time and the mixer's playing mask). Output channel: o_valid / i_ready
// carry one result per request (ok, channel, halt flag and channel, start time).
// Configuration: i_cfg_we writes i_cfg_data into the play limit at once.
// A request runs down a row of CHANNELS cells, one cell per cycle, each cell
// holding one slot and folding its match, age and free state into the result.
// The result passes from the last cell into a capture register and then into the
// output register; the next request is taken only after the result has entered
// the output register, so the block holds one request in the row at a time.
// The output register lets a new request start while the last result waits.
// If the receiver stalls, the finished result of the following request holds
// at the end of the row and the block takes nothing more until it moves on.
// Synchronous reset clears every slot to sound id zero and tick zero, sets the
// play limit to 3 and empties the row and the output register.
module voice_channel_allocator import vca_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [LIMIT_W-1:0]        i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_req_type,
    input  logic [SOUND_W-1:0]        i_sound_id,
    input  logic [TICK_W-1:0]         i_current_tick,
    input  logic signed [PTIME_W-1:0] i_play_time,
    input  logic [MASK_W-1:0]         i_playing_mask,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_ok,
    output logic [CHAN_W-1:0]         o_act_channel,
    output logic                      o_halt_valid,
    output logic [CHAN_W-1:0]         o_halt_channel,
    output logic signed [PTIME_W-1:0] o_start_time
);

    localparam int CMP_W = (CH_CNT_W > LIMIT_W) ? CH_CNT_W : LIMIT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                    r_state;
    t_state                    n_state;
    logic [LIMIT_W-1:0]        r_limit;
    t_req                      r_req;
    logic [TICK_W-1:0]         r_tick;
    logic signed [PTIME_W-1:0] r_ptime;
    logic                      r_start;
    t_carry                    r_fin;
    t_carry                    w_carry [CHANNELS+1];
    t_wr                       w_wr;
    logic                      w_take;
    logic                      w_commit;
    logic                      w_halt;
    logic                      w_ok;
    logic [CH_IDX_W-1:0]       w_sel;
    logic                      r_o_valid;
    logic                      r_o_ok;
    logic [CHAN_W-1:0]         r_o_act;
    logic                      r_o_halt;
    logic [CHAN_W-1:0]         r_o_halt_ch;
    logic signed [PTIME_W-1:0] r_o_start;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_take   = i_valid && o_ready;
    assign w_commit = (r_state == ST_DONE) && (!r_o_valid || i_ready);

    // Hold the play limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Sequence a request through the row
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_take) n_state = ST_RUN;
            ST_RUN:  if (w_carry[CHANNELS].valid) n_state = ST_DONE;
            ST_DONE: if (w_commit) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_take;
        end
    end

    // Hold the request fields for the length of the pass
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req.play  <= (i_req_type == REQ_PLAY);
            r_req.sound <= i_sound_id;
            r_req.mask  <= i_playing_mask;
            r_tick      <= i_current_tick;
            r_ptime     <= i_play_time;
        end
    end

    // Feed an empty partial result into the first cell
    assign w_carry[0] = {r_start, {($bits(t_carry)-1){1'b0}}};

    for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
        vca_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (r_req),
            .i_carry (w_carry[g]),
            .i_wr    (w_wr),
            .o_carry (w_carry[g+1])
        );
    end

    // Capture the result at the end of the row
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_RUN) && w_carry[CHANNELS].valid) begin
            r_fin <= w_carry[CHANNELS];
        end
    end

    // Decide the steal and the channel to use
    always_comb begin
        w_halt = r_req.play && r_fin.found &&
                 (CMP_W'(r_fin.cnt) >= CMP_W'(r_limit));
        if (r_req.play) begin
            w_ok = w_halt || r_fin.free_found;
            if (w_halt && (!r_fin.free_found || (r_fin.best_idx < r_fin.free_idx))) begin
                w_sel = r_fin.best_idx;
            end else begin
                w_sel = r_fin.free_idx;
            end
        end else begin
            w_ok  = r_fin.match_found;
            w_sel = r_fin.match_idx;
        end
    end

    // Record the sound in the chosen slot on a successful play
    always_comb begin
        w_wr.en    = w_commit && r_req.play && w_ok;
        w_wr.idx   = w_sel;
        w_wr.sound = r_req.sound;
        w_wr.tick  = r_tick;
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_commit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_o_ok      <= w_ok;
            r_o_act     <= w_ok ? CHAN_W'(w_sel) : '0;
            r_o_halt    <= w_halt;
            r_o_halt_ch <= w_halt ? CHAN_W'(r_fin.best_idx) : '0;
            r_o_start   <= (r_req.play && w_ok) ? r_ptime : '0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_ok           = r_o_ok;
    assign o_act_channel  = r_o_act;
    assign o_halt_valid   = r_o_halt;
    assign o_halt_channel = r_o_halt_ch;
    assign o_start_time   = r_o_start;

endmodule

// ===== design/vca_cell.sv =====
module vca_cell import vca_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_req   i_req,
    input  t_carry i_carry,
    input  t_wr    i_wr,
    output t_carry o_carry
);

    localparam logic [CH_IDX_W-1:0]   MY_IDX   = CH_IDX_W'(IDX);
    localparam bit                    HAS_MASK = (IDX < MASK_W);
    localparam logic [MASK_BIT_W-1:0] MASK_BIT = MASK_BIT_W'(IDX % MASK_W);

    logic [SOUND_W-1:0] r_sound;
    logic [TICK_W-1:0]  r_tick;
    t_carry             r_carry;
    t_carry             n_carry;
    logic               w_playing;
    logic               w_hit;

    // Channels without a mask bit never count as playing
    assign w_playing = HAS_MASK && i_req.mask[MASK_BIT];
    assign w_hit     = (r_sound == i_req.sound);

    // Fold this slot into the running result
    always_comb begin
        n_carry = i_carry;
        if (i_req.play) begin
            if (w_hit && w_playing) begin
                n_carry.cnt = i_carry.cnt + CH_CNT_W'(1);
                if (!i_carry.found || (r_tick < i_carry.best_tick)) begin
                    n_carry.found     = 1'b1;
                    n_carry.best_idx  = MY_IDX;
                    n_carry.best_tick = r_tick;
                end
            end
            if (!w_playing && !i_carry.free_found) begin
                n_carry.free_found = 1'b1;
                n_carry.free_idx   = MY_IDX;
            end
        end else if (w_hit && !i_carry.match_found) begin
            n_carry.match_found = 1'b1;
            n_carry.match_idx   = MY_IDX;
        end
    end

    // Advance the partial result to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry.valid <= 1'b0;
        end else begin
            r_carry.valid <= i_carry.valid;
        end
        r_carry.cnt         <= n_carry.cnt;
        r_carry.found       <= n_carry.found;
        r_carry.best_idx    <= n_carry.best_idx;
        r_carry.best_tick   <= n_carry.best_tick;
        r_carry.free_found  <= n_carry.free_found;
        r_carry.free_idx    <= n_carry.free_idx;
        r_carry.match_found <= n_carry.match_found;
        r_carry.match_idx   <= n_carry.match_idx;
    end

    assign o_carry = r_carry;

    // Record a new sound when the write picks this slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sound <= '0;
            r_tick  <= '0;
        end else if (i_wr.en && (i_wr.idx == MY_IDX)) begin
            r_sound <= i_wr.sound;
            r_tick  <= i_wr.tick;
        end
    end

endmodule

// ===== tb/tb_voice_channel_allocator.sv =====
`timescale 1ns / 100ps

module tb_voice_channel_allocator;
    import vca_pkg::*;

    localparam int N_CH           = CHANNELS_DEF;
    localparam int PIPE_LAT       = N_CH + 3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_PER_PHASE = 266;

    // One request as driven on the input channel
    typedef struct packed {
        t_req_type                req;
        logic [SOUND_W-1:0]       sound;
        logic [TICK_W-1:0]        tick;
        logic signed [PTIME_W-1:0] ptime;
        logic [MASK_W-1:0]        mask;
    } t_voice_req;

    // One result as seen on the output channel
    typedef struct packed {
        logic                      ok;
        logic [CHAN_W-1:0]         act;
        logic                      halt_v;
        logic [CHAN_W-1:0]         halt_ch;
        logic signed [PTIME_W-1:0] start;
    } t_voice_res;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [LIMIT_W-1:0]        i_cfg_data;
    logic                      i_valid;
    logic                      o_ready;
    logic [1:0]                i_req_type;
    logic [SOUND_W-1:0]        i_sound_id;
    logic [TICK_W-1:0]         i_current_tick;
    logic signed [PTIME_W-1:0] i_play_time;
    logic [MASK_W-1:0]         i_playing_mask;
    logic                      o_valid;
    logic                      i_ready;
    logic                      o_ok;
    logic [CHAN_W-1:0]         o_act_channel;
    logic                      o_halt_valid;
    logic [CHAN_W-1:0]         o_halt_channel;
    logic signed [PTIME_W-1:0] o_start_time;

    // Shadow of the block's slots and play limit
    logic [SOUND_W-1:0] chan_sound [N_CH];
    logic [TICK_W-1:0]  chan_tick  [N_CH];
    logic [LIMIT_W-1:0] limit_q;

    t_voice_req pending_reqs[$];
    t_voice_res expected_results[$];
    t_voice_req driven_req;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          errors;
    int          quiet_cycles;
    logic [31:0] cycle_cnt;

    // Stimulus shaping state
    logic [MASK_W-1:0] mixer_mask;
    logic [TICK_W-1:0] run_tick;

    voice_channel_allocator #(.CHANNELS(N_CH)) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_req_type     (i_req_type),
        .i_sound_id     (i_sound_id),
        .i_current_tick (i_current_tick),
        .i_play_time    (i_play_time),
        .i_playing_mask (i_playing_mask),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_ok           (o_ok),
        .o_act_channel  (o_act_channel),
        .o_halt_valid   (o_halt_valid),
        .o_halt_channel (o_halt_channel),
        .o_start_time   (o_start_time)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Work out the result of one request and advance the slot shadow
    function automatic t_voice_res allocate_voice(input t_voice_req r);
        t_voice_res        res;
        int                cnt;
        bit                found;
        int                oldest;
        logic [TICK_W-1:0] oldest_tick;
        logic [MASK_W-1:0] busy;
        res         = '0;
        cnt         = 0;
        found       = 1'b0;
        oldest      = 0;
        oldest_tick = '0;
        busy        = r.mask;
        if (r.req == REQ_PLAY) begin
            // count playing copies and find the oldest one
            for (int i = 0; i < N_CH; i++) begin
                if (chan_sound[i] == r.sound && busy[i]) begin
                    cnt++;
                    if (!found || chan_tick[i] < oldest_tick) begin
                        found       = 1'b1;
                        oldest      = i;
                        oldest_tick = chan_tick[i];
                    end
                end
            end
            // steal the oldest copy once the limit is reached
            if (found && cnt >= int'(limit_q)) begin
                res.halt_v  = 1'b1;
                res.halt_ch = CHAN_W'(oldest);
                busy[oldest] = 1'b0;
            end
            // take the first idle channel
            for (int i = 0; i < N_CH; i++) begin
                if (!busy[i]) begin
                    chan_sound[i] = r.sound;
                    chan_tick[i]  = r.tick;
                    res.ok        = 1'b1;
                    res.act       = CHAN_W'(i);
                    res.start     = r.ptime;
                    break;
                end
            end
        end else begin
            // first slot holding the sound, playing or not
            for (int i = 0; i < N_CH; i++) begin
                if (chan_sound[i] == r.sound) begin
                    res.ok  = 1'b1;
                    res.act = CHAN_W'(i);
                    break;
                end
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic add_req(input t_req_type req, input logic [SOUND_W-1:0] sound,
                           input logic [TICK_W-1:0] tick, input logic [31:0] ptime,
                           input logic [MASK_W-1:0] mask);
        t_voice_req r;
        r.req   = req;
        r.sound = sound;
        r.tick  = tick;
        r.ptime = ptime;
        r.mask  = mask;
        pending_reqs.push_back(r);
    endtask

    // Random requests: mostly plays of a few sounds against an evolving mixer mask
    task automatic gen_random(input int n);
        t_voice_req r;
        int         roll;
        for (int k = 0; k < n; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                r.req = REQ_PLAY;
            else
                r.req = t_req_type'($urandom_range(0, 3));

            roll = $urandom_range(0, 99);
            if (roll < 70)
                r.sound = SOUND_W'($urandom_range(1, 3));
            else if (roll < 85)
                r.sound = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h8000;
            else
                r.sound = SOUND_W'($urandom_range(1, 65535));

            roll = $urandom_range(0, 99);
            if (roll < 5)
                run_tick = $urandom;
            else if (roll < 7)
                run_tick = '1;
            else
                run_tick = run_tick + TICK_W'($urandom_range(0, 20));
            r.tick = run_tick;

            roll = $urandom_range(0, 99);
            if (roll < 20)
                r.ptime = -1;
            else if (roll < 25)
                r.ptime = 32'h7FFF_FFFF;
            else if (roll < 30)
                r.ptime = 0;
            else
                r.ptime = $urandom & 32'h7FFF_FFFF;

            roll = $urandom_range(0, 99);
            if (roll < 10)
                r.mask = MASK_W'($urandom_range(0, 255));
            else if (roll < 13)
                r.mask = '1;
            else if (roll < 16)
                r.mask = '0;
            else
                r.mask = mixer_mask;

            // let the mixer mask follow the traffic loosely
            if (r.req == REQ_PLAY)
                mixer_mask[$urandom_range(0, N_CH - 1)] = 1'b1;
            else if (r.req == REQ_STOP || $urandom_range(0, 3) == 0)
                mixer_mask[$urandom_range(0, N_CH - 1)] = 1'b0;

            pending_reqs.push_back(r);
        end
    endtask

    // Hold until every request is through and the row has emptied
    task automatic wait_drained;
        while (pending_reqs.size() != 0 || i_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (PIPE_LAT + 2) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        limit_q     = value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int send_pct,
                             input int recv_pct);
        wait_drained();
        write_limit(limit);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        gen_random(RAND_PER_PHASE);
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                expected_results.push_back(allocate_voice(driven_req));
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() != 0 &&
                    !(cycle_cnt[6:5] != 2'd0 && $urandom_range(0, 99) < send_idle_pct)) begin
                    driven_req      = pending_reqs.pop_front();
                    i_valid        <= 1'b1;
                    i_req_type     <= driven_req.req;
                    i_sound_id     <= driven_req.sound;
                    i_current_tick <= driven_req.tick;
                    i_play_time    <= driven_req.ptime;
                    i_playing_mask <= driven_req.mask;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result mismatch, expected none actual ok=%0b ch=%0d",
                             $time, o_ok, o_act_channel);
                end else begin
                    t_voice_res exp_r;
                    exp_r = expected_results.pop_front();
                    check_field("ok", 32'(exp_r.ok), 32'(o_ok));
                    check_field("act_channel", 32'(exp_r.act), 32'(o_act_channel));
                    check_field("halt_valid", 32'(exp_r.halt_v), 32'(o_halt_valid));
                    check_field("halt_channel", 32'(exp_r.halt_ch), 32'(o_halt_channel));
                    check_field("start_time", exp_r.start, o_start_time);
                end
            end
            i_ready <= !(cycle_cnt[6:5] != 2'd0 && $urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_req_type     = '0;
        i_sound_id     = '0;
        i_current_tick = '0;
        i_play_time    = '0;
        i_playing_mask = '0;
        errors         = 0;
        quiet_cycles   = 0;
        cycle_cnt      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mixer_mask     = '0;
        run_tick       = 32'd1000;
        limit_q        = LIMIT_RESET;
        for (int i = 0; i < N_CH; i++) begin
            chan_sound[i] = '0;
            chan_tick[i]  = '0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset limit
        add_req(REQ_STOP,   16'd5,    32'd0,   32'd0,        8'h00); // sound not present
        add_req(REQ_PAUSE,  16'd0,    32'd0,   32'd0,        8'h00); // id zero hits empty slot
        add_req(REQ_PLAY,   16'd1,    32'd100, 32'hFFFF_FFFF, 8'h00);
        add_req(REQ_PLAY,   16'd1,    32'd200, 32'h7FFF_FFFF, 8'h01);
        add_req(REQ_PLAY,   16'd1,    32'd50,  32'd0,        8'h03);
        add_req(REQ_PLAY,   16'd1,    32'd300, 32'd1234,     8'h07); // limit reached, steal
        add_req(REQ_PLAY,   16'd1,    32'd300, 32'd99,       8'h07);
        add_req(REQ_PLAY,   16'hFFFF, 32'hFFFF_FFFF, 32'd7,  8'hFF); // no free channel
        add_req(REQ_PLAY,   16'hFFFF, 32'hFFFF_FFFF, 32'd8,  8'h07);
        add_req(REQ_PLAY,   16'hFFFF, 32'hFFFF_FFFF, 32'd9,  8'h0F);
        add_req(REQ_PLAY,   16'hFFFF, 32'hFFFF_FFFF, 32'd10, 8'h1F);
        add_req(REQ_PLAY,   16'hFFFF, 32'hFFFF_FFFF, 32'd11, 8'h3F); // all-ones ticks stolen
        add_req(REQ_RESUME, 16'd1,    32'd0,   32'd0,        8'hFF);
        add_req(REQ_PAUSE,  16'hFFFF, 32'd0,   32'd0,        8'h00);
        add_req(REQ_STOP,   16'd1,    32'd0,   32'd0,        8'h55);
        add_req(REQ_PLAY,   16'd2,    32'd7,   32'd1,        8'h00);
        add_req(REQ_PLAY,   16'd2,    32'd7,   32'd2,        8'h01);
        add_req(REQ_PLAY,   16'd2,    32'd7,   32'd3,        8'h03); // tied ticks
        add_req(REQ_PLAY,   16'd2,    32'd7,   32'd4,        8'hFF); // steal with full mask
        add_req(REQ_PLAY,   16'd0,    32'd0,   32'h8000_0000, 8'hFE);
        add_req(REQ_RESUME, 16'hABCD, 32'd0,   32'd0,        8'h00);

        run_phase(4'd1,  0,  0);
        run_phase(4'd8,  71, 0);
        run_phase(4'd0,  0,  71);
        run_phase(4'd15, 10, 10);
        run_phase(LIMIT_W'($urandom_range(2, 7)), 0, 0);

        wait_drained();
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
